>>> hw/rtl/ata_pkg.sv
// ata_pkg: shared constants and table function for the tilt angle pipeline
// arctangent table (Q30 radians), CORDIC gain reciprocal and conversion scales
`timescale 1ns / 1ps
`default_nettype none
package ata_pkg;
  localparam int SampleBits = 16;
  localparam int TableLen = 24;
  localparam int GuardBits = 6;
  localparam logic [29:0] InvGainQ30 = 30'd652032874;
  localparam logic [31:0] PiQ30 = 32'd3373259426;
  localparam logic [28:0] CdegPerRadQ16 = 29'd375493621;

  function automatic logic [29:0] atan_q30(input int idx);
    logic [29:0] t;
    case (idx)
      0: t = 30'd843314857;
      1: t = 30'd497837829;
      2: t = 30'd263043837;
      3: t = 30'd133525159;
      4: t = 30'd67021687;
      5: t = 30'd33543516;
      6: t = 30'd16775851;
      7: t = 30'd8388437;
      8: t = 30'd4194283;
      9: t = 30'd2097149;
      default: t = (idx < TableLen) ? (30'd1 << (30 - idx)) : 30'd0;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/accel_tilt_angles_unit.sv
// accel_tilt_angles_unit: roll and pitch from one accelerometer sample
// throughput: one sample per cycle while the output is not stalled; all four CORDIC rows are pipelined
// stall: the whole pipe advances only when its output register can move
// reset: synchronous rst clears the valid bits only
`timescale 1ns / 1ps
`default_nettype none
module accel_tilt_angles_unit
  import ata_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // accel_x, accel_y, accel_z
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // roll_angle[14:0], pitch_angle[15:0], zero pad
);
  localparam int N = (CORDIC_STAGES > TableLen) ? TableLen : CORDIC_STAGES;
  localparam int W = SampleBits + GuardBits + 4;
  localparam int LAT = 2 * N + 5;
  localparam int SW = 2 * SampleBits + 2;

  // the pipe moves as a whole; a skid-free stall keeps every stage
  logic adv;
  logic [LAT-1:0] vld;
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage 0: register inputs
  logic signed [SampleBits-1:0] ax, ay, az;
  always_ff @(posedge clk) begin
    if (s_tvalid && adv) begin
      ax <= s_tdata[SampleBits-1:0];
      ay <= s_tdata[16+SampleBits-1:16];
      az <= s_tdata[32+SampleBits-1:32];
    end
  end

  // magnitude rows: |x|,|z| and |y|,|z|
  logic signed [W-1:0] mxa, mza, mya;
  assign mxa = ax[SampleBits-1] ? -(W'(ax) <<< GuardBits) : (W'(ax) <<< GuardBits);
  assign mya = ay[SampleBits-1] ? -(W'(ay) <<< GuardBits) : (W'(ay) <<< GuardBits);
  assign mza = az[SampleBits-1] ? -(W'(az) <<< GuardBits) : (W'(az) <<< GuardBits);

  logic signed [W-1:0] m1x, m1y, m2x, m2y;
  logic signed [33:0] m1z, m2z;
  logic [SW-1:0] side1;
  ata_cordic_chain #(.W(W), .Stages(N), .SideW(SW)) u_mag1 (
    .clk(clk), .en(adv), .x_in(mxa), .y_in(mza), .z_in(34'sd0),
    .side_in({ax, ay, az[SampleBits-1], 1'b0}),
    .x_out(m1x), .y_out(m1y), .z_out(m1z), .side_out(side1)
  );
  ata_cordic_chain #(.W(W), .Stages(N), .SideW(1)) u_mag2 (
    .clk(clk), .en(adv), .x_in(mya), .y_in(mza), .z_in(34'sd0), .side_in(1'b0),
    .x_out(m2x), .y_out(m2y), .z_out(m2z), .side_out()
  );

  // gain removal: product registered, then rounding
  logic [W+29:0] p1, p2;
  logic [SW-1:0] side2;
  always_ff @(posedge clk) begin
    if (adv) begin
      p1 <= (m1x[W-1] ? '0 : (W+30)'(m1x)) * (W+30)'(InvGainQ30);
      p2 <= (m2x[W-1] ? '0 : (W+30)'(m2x)) * (W+30)'(InvGainQ30);
      side2 <= side1;
    end
  end
  logic signed [W-1:0] mag_xz, mag_yz;
  assign mag_xz = W'((p1 + (W+30)'(1 << 29)) >> 30);
  assign mag_yz = W'((p2 + (W+30)'(1 << 29)) >> 30);

  // set up atan2 rows
  logic signed [SampleBits-1:0] sx, sy;
  logic zneg;
  assign sx = side2[SW-1 -: SampleBits];
  assign sy = side2[SW-1-SampleBits -: SampleBits];
  assign zneg = side2[1];
  logic signed [W-1:0] nr, np, dp;
  assign nr = W'(sy) <<< GuardBits;
  assign np = W'(sx) <<< GuardBits;
  assign dp = zneg ? -mag_yz : mag_yz;

  logic signed [W-1:0] rx0, ry0, px0, py0;
  logic signed [33:0] pz0;
  logic rzero, pzero;
  always_ff @(posedge clk) begin
    if (adv) begin
      rx0 <= mag_xz;
      ry0 <= nr;
      rzero <= (nr == '0) && (mag_xz == '0);
      pzero <= (np == '0) && (dp == '0);
      if (dp[W-1]) begin
        px0 <= -dp;
        py0 <= -np;
        pz0 <= np[W-1] ? -signed'({2'd0, PiQ30}) : signed'({2'd0, PiQ30});
      end else begin
        px0 <= dp;
        py0 <= np;
        pz0 <= '0;
      end
    end
  end

  logic signed [W-1:0] rxo, ryo, pxo, pyo;
  logic signed [33:0] rzo, pzo;
  logic [1:0] zf;
  ata_cordic_chain #(.W(W), .Stages(N), .SideW(2)) u_roll (
    .clk(clk), .en(adv), .x_in(rx0), .y_in(ry0), .z_in(34'sd0), .side_in({rzero, pzero}),
    .x_out(rxo), .y_out(ryo), .z_out(rzo), .side_out(zf)
  );
  ata_cordic_chain #(.W(W), .Stages(N), .SideW(1)) u_pitch (
    .clk(clk), .en(adv), .x_in(px0), .y_in(py0), .z_in(pz0), .side_in(1'b0),
    .x_out(pxo), .y_out(pyo), .z_out(pzo), .side_out()
  );

  // conversion to hundredths of a degree: |z| * scale, registered
  logic [62:0] cr, cp;
  logic rn, pn;
  logic [1:0] zf2;
  always_ff @(posedge clk) begin
    if (adv) begin
      cr <= 63'(rzo[33] ? -rzo : rzo) * 63'(CdegPerRadQ16);
      cp <= 63'(pzo[33] ? -pzo : pzo) * 63'(CdegPerRadQ16);
      rn <= rzo[33];
      pn <= pzo[33];
      zf2 <= zf;
    end
  end
  logic [16:0] rr, pr;
  assign rr = 17'((cr + 63'(64'd1 << 45)) >> 46);
  assign pr = 17'((cp + 63'(64'd1 << 45)) >> 46);
  logic signed [15:0] roll_v, pitch_v;
  always_comb begin
    if (zf2[1]) roll_v = '0;
    else if (rr > 17'd9000) roll_v = rn ? -16'sd9000 : 16'sd9000;
    else roll_v = rn ? -16'(rr) : 16'(rr);
    if (zf2[0]) pitch_v = '0;
    else if (pr > 17'd18000) pitch_v = pn ? -16'sd18000 : 16'sd18000;
    else pitch_v = pn ? -16'(pr) : 16'(pr);
  end

  logic [14:0] roll_q;
  logic [15:0] pitch_q;
  always_ff @(posedge clk) begin
    if (adv) begin
      roll_q <= roll_v[14:0];
      pitch_q <= pitch_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end
  assign m_tvalid = vld[LAT-1];
  assign m_tdata = {1'b0, pitch_q, roll_q};

  // unused residues of the CORDIC rows
  logic unused;
  assign unused = ^{m1y, m1z, m2y, m2z, rxo, ryo, pxo, pyo, side2[0], p1[29:0], p2[29:0],
                    roll_v[15], cr[45:0], cp[45:0]};
endmodule
`default_nettype wire

>>> hw/rtl/ata_cordic_cell.sv
// ata_cordic_cell: one registered CORDIC vectoring step (x, y, angle)
// depends on ata_pkg for the arctangent table
`timescale 1ns / 1ps
`default_nettype none
module ata_cordic_cell
  import ata_pkg::*;
#(
  parameter int W = 48,
  parameter int Stage = 0
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [W-1:0] x_in,
  input  wire logic signed [W-1:0] y_in,
  input  wire logic signed [33:0]  z_in,
  output logic signed [W-1:0]      x_out,
  output logic signed [W-1:0]      y_out,
  output logic signed [33:0]       z_out
);
  logic signed [W-1:0] dx;
  logic signed [W-1:0] dy;
  logic signed [33:0] a;
  assign dx = y_in >>> Stage;
  assign dy = x_in >>> Stage;
  assign a = signed'({4'd0, atan_q30(Stage)});
  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[W-1]) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + a;
      end else begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - a;
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/ata_cordic_chain.sv
// ata_cordic_chain: row of CORDIC cells with matching pipeline of side data
// depends on ata_pkg and ata_cordic_cell
`timescale 1ns / 1ps
`default_nettype none
module ata_cordic_chain
  import ata_pkg::*;
#(
  parameter int W = 48,
  parameter int Stages = 16,
  parameter int SideW = 8
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [W-1:0] x_in,
  input  wire logic signed [W-1:0] y_in,
  input  wire logic signed [33:0]  z_in,
  input  wire logic [SideW-1:0]    side_in,
  output logic signed [W-1:0]      x_out,
  output logic signed [W-1:0]      y_out,
  output logic signed [33:0]       z_out,
  output logic [SideW-1:0]         side_out
);
  logic signed [W-1:0] xs [Stages+1];
  logic signed [W-1:0] ys [Stages+1];
  logic signed [33:0] zs [Stages+1];
  logic [SideW-1:0] ss [Stages+1];
  assign xs[0] = x_in;
  assign ys[0] = y_in;
  assign zs[0] = z_in;
  assign ss[0] = side_in;
  for (genvar i = 0; i < Stages; i++) begin : g_cell
    ata_cordic_cell #(.W(W), .Stage(i)) u_cell (
      .clk(clk), .en(en), .x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]),
      .x_out(xs[i+1]), .y_out(ys[i+1]), .z_out(zs[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) ss[i+1] <= ss[i];
    end
  end
  assign x_out = xs[Stages];
  assign y_out = ys[Stages];
  assign z_out = zs[Stages];
  assign side_out = ss[Stages];
endmodule
`default_nettype wire

>>> hw/rtl/ata_checker.sv
// ata_checker: port-level assertions for accel_tilt_angles_unit
// bound to the top level; sees only its ports
`timescale 1ns / 1ps
`default_nettype none
module ata_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready) else $error("ready");
  a_roll: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[14:0]) <= 15'sd9000 &&
                  $signed(m_tdata[14:0]) >= -15'sd9000)) else $error("roll");
  a_pitch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[30:15]) <= 16'sd18000 &&
                  $signed(m_tdata[30:15]) >= -16'sd18000)) else $error("pitch");
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid) else $error("reset");
endmodule

bind accel_tilt_angles_unit ata_checker u_ata_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
